FILE: sv/ndwd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndwd_pkg: shared types and constants of the work-group dispatcher
// Beat layouts of the request and result channels, the load bundle of the
// group walker, command and register codes, fixed sizes.
// ----------------------------------------------------------------------------
package ndwd_pkg;

    // Fixed sizes
    localparam int DATA_W      = 32;
    localparam int LSZ_W       = 11;
    localparam int NUM_AXES    = 3;   // storage for three dimensions
    localparam int NUM_DIMS    = 3;   // most dimensions a launch may use
    localparam int MAX_CORES   = 8;   // core count saturates here
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 4;
    localparam int CORES_W     = 4;
    localparam int CORE_ID_W   = 3;

    typedef logic [DATA_W-1:0] word_t;
    typedef logic [LSZ_W-1:0]  lsz_t;

    // Commands
    localparam logic CMD_LAUNCH = 1'b0;
    localparam logic CMD_NEXT   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_CORE_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CORE_INDEX = 1'b1;

    // Request beat
    typedef struct packed {
        logic       cmd;
        logic [1:0] num_dims;
        word_t      global_size_x;
        word_t      global_size_y;
        word_t      global_size_z;
        lsz_t       local_size_x;
        lsz_t       local_size_y;
        lsz_t       local_size_z;
        word_t      offset_x;
        word_t      offset_y;
        word_t      offset_z;
        logic       debug_mode;
    } req_t;

    // Result beat
    typedef struct packed {
        logic  valid_res;
        word_t group_start_x;
        word_t group_start_y;
        word_t group_start_z;
        word_t group_number;
        logic  last_group;
    } rsp_t;

    // Range description handed to the group walker at launch
    typedef struct packed {
        word_t [NUM_AXES-1:0] limit;
        word_t [NUM_AXES-1:0] offset;
        lsz_t  [NUM_AXES-1:0] size;
        logic  [1:0]          dims;
        word_t                first_id;
    } walk_load_t;

endpackage

FILE: sv/ndwd_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndwd_stream_if: valid/ready channel
// One beat moves at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface ndwd_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source
    (
        output valid,
        output data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  data,
        output ready
    );
endinterface

FILE: sv/ndwd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndwd_div: shared iterative divider
// Unsigned 32 / 32 restoring division, one quotient bit per cycle.
// done is high for a single cycle as the last step's results register; results hold until next start.
// ----------------------------------------------------------------------------
module ndwd_div
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [ndwd_pkg::DATA_W-1:0] dividend,
    input  logic [ndwd_pkg::DATA_W-1:0] divisor,
    output logic                  done,
    output logic [ndwd_pkg::DATA_W-1:0] quotient,
    output logic [ndwd_pkg::DATA_W-1:0] remainder
);
    import ndwd_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    word_t            rem_reg, rem_next;
    word_t            quo_reg, quo_next;
    word_t            dvs_reg, dvs_next;

    logic [DATA_W:0]  shifted;
    logic [DATA_W:0]  diff;
    logic             fits;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DATA_W-1]};
        diff    = shifted - {1'b0, dvs_reg};
        fits    = shifted >= {1'b0, dvs_reg};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;

        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '1;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: sv/ndwd_walk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndwd_walk: work-group walker
// Holds the core's chunk of the range and its group counter vector. Gives
// the current group and steps the counters on request, x fastest.
// ----------------------------------------------------------------------------
module ndwd_walk #(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 load,
    input  ndwd_pkg::walk_load_t load_data,
    input  logic                 step,
    output logic                 active,
    output ndwd_pkg::rsp_t       res
);
    import ndwd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > DATA_W) ? COUNT_WIDTH : DATA_W;

    logic                   active_reg, active_next;
    logic [1:0]             dims_reg, dims_next;
    word_t                  ngn_reg, ngn_next;
    logic [COUNT_WIDTH-1:0] gc_reg   [NUM_AXES];
    logic [COUNT_WIDTH-1:0] gc_next  [NUM_AXES];
    word_t                  limit_reg  [NUM_AXES];
    word_t                  offset_reg [NUM_AXES];
    lsz_t                   size_reg   [NUM_AXES];

    logic [COUNT_WIDTH-1:0] cnt_sum [NUM_AXES];
    logic [NUM_AXES-1:0]    lt;
    logic [NUM_AXES-1:0]    used;
    logic [NUM_AXES-1:0]    reach;
    logic                   done;

    // Counter step per axis, all in parallel
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            cnt_sum[i] = gc_reg[i] + COUNT_WIDTH'(size_reg[i]);
            lt[i]      = CMP_W'(cnt_sum[i]) < CMP_W'(limit_reg[i]);
            used[i]    = 2'(i) < dims_reg;
        end
        // an axis is touched only when every lower axis rolled over
        reach[0] = 1'b1;
        for (int i = 1; i < NUM_AXES; i++)
        begin
            reach[i] = reach[i-1] & ~lt[i-1];
        end
        done = &(~used | ~lt);
    end

    // Next state
    always_comb
    begin
        active_next = active_reg;
        dims_next   = dims_reg;
        ngn_next    = ngn_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            gc_next[i] = gc_reg[i];
        end

        if (clear)
        begin
            active_next = 1'b0;
        end
        else if (load)
        begin
            active_next = 1'b1;
            dims_next   = load_data.dims;
            ngn_next    = load_data.first_id;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gc_next[i] = '0;
            end
        end
        else if (step)
        begin
            ngn_next = ngn_reg + 1'b1;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                if (used[i] && reach[i])
                begin
                    gc_next[i] = lt[i] ? cnt_sum[i] : '0;
                end
            end
            if (done)
            begin
                active_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            dims_reg   <= 2'd1;
            ngn_reg    <= '0;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gc_reg[i] <= '0;
            end
        end
        else
        begin
            active_reg <= active_next;
            dims_reg   <= dims_next;
            ngn_reg    <= ngn_next;
            for (int i = 0; i < NUM_AXES; i++)
            begin
                gc_reg[i] <= gc_next[i];
            end
        end
    end

    // Chunk description, written at launch only
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < NUM_AXES; i++)
            begin
                limit_reg[i]  <= load_data.limit[i];
                offset_reg[i] <= load_data.offset[i];
                size_reg[i]   <= load_data.size[i];
            end
        end
    end

    // Current group
    always_comb
    begin
        res.valid_res     = 1'b1;
        res.group_start_x = offset_reg[0] + DATA_W'(gc_reg[0]);
        res.group_start_y = offset_reg[1] + DATA_W'(gc_reg[1]);
        res.group_start_z = offset_reg[2] + DATA_W'(gc_reg[2]);
        res.group_number  = ngn_reg;
        res.last_group    = done;
    end

    assign active = active_reg;

endmodule

FILE: sv/ndrange_workgroup_dispatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ndrange_workgroup_dispatch: per-core NDRange work-group dispatcher
// Launch beats set up this core's share of the range; each beat on req
// returns exactly one beat on rsp (a work-group, or valid_res low).
// ----------------------------------------------------------------------------
// Usage
//   req (sink): launch (cmd low) or next-group request (cmd high).
//   rsp (source): one beat per request, held in an output register.
//   cfg_we/cfg_index/cfg_wdata: core_count (index 0), core_index (index 1);
//   write only while the block is idle.
// Timing
//   A next-group request is answered from the walker state: the result is
//   registered at the accepting edge, and req is ready again as soon as the
//   output register is empty or rsp.ready is high.
//   A launch runs on one shared 1-bit-per-cycle divider and one shared
//   32x32 multiplier. The split search does up to two divisions per
//   dimension tried, then the first group id needs five multiplies and one
//   division.
// Reset
//   core_count = 1, core_index = 0, no active range, output register empty.
// Backpressure
//   req is held off while the output register holds a beat that is not
//   taken; a stalled rsp stalls nothing inside beyond that.
// ----------------------------------------------------------------------------
module ndrange_workgroup_dispatch #(
    parameter int COUNT_WIDTH = 32
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ndwd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ndwd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    ndwd_stream_if.sink                         req,
    ndwd_stream_if.source                       rsp
);
    import ndwd_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_D1GO    = 4'd1;
    localparam logic [3:0] S_D1WAIT  = 4'd2;
    localparam logic [3:0] S_D2GO    = 4'd3;
    localparam logic [3:0] S_D2WAIT  = 4'd4;
    localparam logic [3:0] S_OFFM    = 4'd5;
    localparam logic [3:0] S_OFFA    = 4'd6;
    localparam logic [3:0] S_P0      = 4'd7;
    localparam logic [3:0] S_P1      = 4'd8;
    localparam logic [3:0] S_P2      = 4'd9;
    localparam logic [3:0] S_L0      = 4'd10;
    localparam logic [3:0] S_L1      = 4'd11;
    localparam logic [3:0] S_D3GO    = 4'd12;
    localparam logic [3:0] S_D3WAIT  = 4'd13;
    localparam logic [3:0] S_EMIT    = 4'd14;

    function automatic lsz_t clamp_lsz(lsz_t v);
        return (v == '0) ? lsz_t'(1) : v;
    endfunction

    // Configuration registers
    logic [CORES_W-1:0]   core_count_reg;
    logic [CORE_ID_W-1:0] core_index_reg;

    // Sequencer and launch registers
    logic [3:0]           state_reg, state_next;
    logic [1:0]           d_reg, d_next;
    logic [1:0]           dims_reg, dims_next;
    logic [CORES_W-1:0]   cores_reg, cores_next;
    logic [CORE_ID_W-1:0] dnum_reg, dnum_next;
    logic [CORE_ID_W-1:0] factor_reg, factor_next;
    logic                 master_reg, master_next;
    word_t                lim_reg [NUM_AXES];
    word_t                lim_next [NUM_AXES];
    word_t                off_reg [NUM_AXES];
    word_t                off_next [NUM_AXES];
    lsz_t                 lsz_reg [NUM_AXES];
    lsz_t                 lsz_next [NUM_AXES];
    word_t                q_reg, q_next;
    word_t                prod_reg, prod_next;
    word_t                lprod_reg, lprod_next;

    // Output register
    rsp_t                 out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // Launch decode
    logic [CORES_W-1:0]   cores_c;
    logic [1:0]           dims_c;
    logic                 master_c;
    logic                 req_fire;
    logic                 nowork;
    logic                 fail_dim;

    // Shared units
    word_t                mul_a, mul_b, mul_p;
    logic [2*DATA_W-1:0]  mul_full;
    logic                 div_start, div_done;
    word_t                div_num, div_den, div_quo, div_rem;

    // Walker hookup
    logic                 walk_clear, walk_load, walk_step, walk_active;
    walk_load_t           walk_ld;
    rsp_t                 walk_res;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || rsp.ready);
    assign req_fire  = req.valid && req.ready;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_count_reg <= CORES_W'(1);
            core_index_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CORE_COUNT: core_count_reg <= cfg_wdata[CORES_W-1:0];
                REG_CORE_INDEX: core_index_reg <= cfg_wdata[CORE_ID_W-1:0];
                default:        core_count_reg <= core_count_reg;
            endcase
        end
    end

    // Core count and dimension clamps
    always_comb
    begin
        if (core_count_reg == '0)
            cores_c = CORES_W'(1);
        else if (core_count_reg > CORES_W'(MAX_CORES))
            cores_c = CORES_W'(MAX_CORES);
        else
            cores_c = core_count_reg;

        if (req.data.num_dims == 2'd0)
            dims_c = 2'd1;
        else if (req.data.num_dims > 2'(NUM_DIMS))
            dims_c = 2'(NUM_DIMS);
        else
            dims_c = req.data.num_dims;

        master_c = (core_index_reg == '0) || (cores_c == CORES_W'(1));
    end

    // Shared multiplier operand select, low word kept
    always_comb
    begin
        unique case (state_reg)
            S_OFFM:
            begin
                mul_a = DATA_W'(dnum_reg);
                mul_b = lim_reg[d_reg];
            end
            S_P0:
            begin
                mul_a = DATA_W'(factor_reg);
                mul_b = lim_reg[0];
            end
            S_P1:
            begin
                mul_a = prod_reg;
                mul_b = lim_reg[1];
            end
            S_P2:
            begin
                mul_a = prod_reg;
                mul_b = lim_reg[2];
            end
            S_L0:
            begin
                mul_a = DATA_W'(lsz_reg[0]);
                mul_b = DATA_W'(lsz_reg[1]);
            end
            S_L1:
            begin
                mul_a = lprod_reg;
                mul_b = DATA_W'(lsz_reg[2]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;
        mul_p    = mul_full[DATA_W-1:0];
    end

    // Shared divider operand select
    always_comb
    begin
        unique case (state_reg)
            S_D1GO:
            begin
                div_num = lim_reg[d_reg];
                div_den = DATA_W'(cores_reg);
            end
            S_D2GO:
            begin
                div_num = q_reg;
                div_den = DATA_W'(lsz_reg[d_reg]);
            end
            S_D3GO:
            begin
                div_num = prod_reg;
                div_den = (lprod_reg == '0) ? DATA_W'(1) : lprod_reg;
            end
            default:
            begin
                div_num = '0;
                div_den = DATA_W'(1);
            end
        endcase
    end

    ndwd_div u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_num),
        .divisor   (div_den),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Range handed to the walker
    always_comb
    begin
        for (int i = 0; i < NUM_AXES; i++)
        begin
            walk_ld.limit[i]  = lim_reg[i];
            walk_ld.offset[i] = off_reg[i];
            walk_ld.size[i]   = lsz_reg[i];
        end
        walk_ld.dims     = dims_reg;
        walk_ld.first_id = div_quo;
    end

    ndwd_walk #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_walk
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (walk_clear),
        .load      (walk_load),
        .load_data (walk_ld),
        .step      (walk_step),
        .active    (walk_active),
        .res       (walk_res)
    );

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        d_next         = d_reg;
        dims_next      = dims_reg;
        cores_next     = cores_reg;
        dnum_next      = dnum_reg;
        factor_next    = factor_reg;
        master_next    = master_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        lprod_next     = lprod_reg;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            lim_next[i] = lim_reg[i];
            off_next[i] = off_reg[i];
            lsz_next[i] = lsz_reg[i];
        end
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        walk_clear     = 1'b0;
        walk_load      = 1'b0;
        walk_step      = 1'b0;
        div_start      = 1'b0;
        nowork         = 1'b0;
        fail_dim       = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    if (req.data.cmd == CMD_NEXT)
                    begin
                        out_next       = walk_active ? walk_res : '0;
                        out_valid_next = 1'b1;
                        walk_step      = walk_active;
                    end
                    else
                    begin
                        // launch: drop any running range, latch the new one
                        walk_clear  = 1'b1;
                        lim_next[0] = req.data.global_size_x;
                        lim_next[1] = req.data.global_size_y;
                        lim_next[2] = req.data.global_size_z;
                        off_next[0] = req.data.offset_x;
                        off_next[1] = req.data.offset_y;
                        off_next[2] = req.data.offset_z;
                        lsz_next[0] = clamp_lsz(req.data.local_size_x);
                        lsz_next[1] = clamp_lsz(req.data.local_size_y);
                        lsz_next[2] = clamp_lsz(req.data.local_size_z);
                        dims_next   = dims_c;
                        cores_next  = cores_c;
                        dnum_next   = core_index_reg;
                        master_next = master_c;
                        factor_next = (cores_c > CORES_W'(1)) ? core_index_reg : '0;
                        d_next      = dims_c - 2'd1;
                        if (req.data.debug_mode)
                        begin
                            if (master_c)
                                state_next = S_P0;
                            else
                                nowork = 1'b1;
                        end
                        else if (cores_c == CORES_W'(1))
                        begin
                            state_next = S_P0;
                        end
                        else
                        begin
                            state_next = S_D1GO;
                        end
                    end
                end
            end
            // global size divisible by core count?
            S_D1GO:
            begin
                div_start  = 1'b1;
                state_next = S_D1WAIT;
            end
            S_D1WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        q_next     = div_quo;
                        state_next = S_D2GO;
                    end
                    else
                    begin
                        fail_dim = 1'b1;
                    end
                end
            end
            // chunk divisible by local size?
            S_D2GO:
            begin
                div_start  = 1'b1;
                state_next = S_D2WAIT;
            end
            S_D2WAIT:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        lim_next[d_reg] = q_reg;
                        state_next      = S_OFFM;
                    end
                    else
                    begin
                        fail_dim = 1'b1;
                    end
                end
            end
            // shift the offset to this core's chunk
            S_OFFM:
            begin
                prod_next  = mul_p;
                state_next = S_OFFA;
            end
            S_OFFA:
            begin
                off_next[d_reg] = off_reg[d_reg] + prod_reg;
                state_next      = S_P0;
            end
            // first group id = core * prod(limits) / prod(local sizes)
            S_P0:
            begin
                prod_next  = mul_p;
                state_next = S_P1;
            end
            S_P1:
            begin
                prod_next  = mul_p;
                state_next = S_P2;
            end
            S_P2:
            begin
                prod_next  = mul_p;
                state_next = S_L0;
            end
            S_L0:
            begin
                lprod_next = mul_p;
                state_next = S_L1;
            end
            S_L1:
            begin
                lprod_next = mul_p;
                state_next = S_D3GO;
            end
            S_D3GO:
            begin
                div_start  = 1'b1;
                state_next = S_D3WAIT;
            end
            S_D3WAIT:
            begin
                if (div_done)
                begin
                    walk_load  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                out_next       = walk_res;
                out_valid_next = 1'b1;
                walk_step      = 1'b1;
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // split test failed: try next lower dim; at x, master runs unsplit
        if (fail_dim)
        begin
            if (d_reg == 2'd0)
            begin
                if (master_reg)
                    state_next = S_P0;
                else
                    nowork = 1'b1;
            end
            else
            begin
                d_next     = d_reg - 2'd1;
                state_next = S_D1GO;
            end
        end

        // no work for this core
        if (nowork)
        begin
            out_next       = '0;
            out_valid_next = 1'b1;
            state_next     = S_IDLE;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Launch datapath and output payload
    always_ff @(posedge clk)
    begin
        d_reg      <= d_next;
        dims_reg   <= dims_next;
        cores_reg  <= cores_next;
        dnum_reg   <= dnum_next;
        factor_reg <= factor_next;
        master_reg <= master_next;
        q_reg      <= q_next;
        prod_reg   <= prod_next;
        lprod_reg  <= lprod_next;
        for (int i = 0; i < NUM_AXES; i++)
        begin
            lim_reg[i] <= lim_next[i];
            off_reg[i] <= off_next[i];
            lsz_reg[i] <= lsz_next[i];
        end
        out_reg    <= out_next;
    end

endmodule

FILE: sim/tb_ndrange_workgroup_dispatch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ndrange_workgroup_dispatch: self-checking bench for the work-group dispatcher
// Drives launch and next-group beats under several core settings and idle
// patterns, predicts every result beat and compares it field by field.
// ----------------------------------------------------------------------------
module tb_ndrange_workgroup_dispatch;
    import ndwd_pkg::*;

    localparam int NUM_PHASES = 12;
    localparam int PHASE_ITEMS = 135;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 260;

    // Tracks this core's share of the range and queues the expected groups
    class dispatch_tracker;
        logic [3:0]  core_count_reg;
        logic [2:0]  core_index_reg;
        bit          range_active;
        logic [31:0] counter[3];
        logic [31:0] limit[3];
        logic [31:0] origin[3];
        logic [10:0] stride[3];
        int unsigned dims_used;
        logic [31:0] next_id;
        rsp_t        expected_groups[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned launches;
        int unsigned splits;
        int unsigned issued;
        int unsigned empties;

        function void reset_state();
            core_count_reg = 4'd1;
            core_index_reg = 3'd0;
            range_active = 1'b0;
            foreach (counter[i])
            begin
                counter[i] = '0;
                limit[i] = '0;
                origin[i] = '0;
                stride[i] = '0;
            end
            dims_used = 1;
            next_id = '0;
            expected_groups.delete();
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [3:0] val);
            if (idx == REG_CORE_COUNT)
                core_count_reg = val;
            else
                core_index_reg = val[2:0];
        endfunction

        function int unsigned outstanding();
            return expected_groups.size();
        endfunction

        // Hand out the current group and step the counters, lowest dim first
        function rsp_t issue_group();
            rsp_t        g;
            logic [31:0] c;
            bit          done;
            int          i;
            g = '0;
            g.valid_res = 1'b1;
            g.group_start_x = origin[0] + counter[0];
            g.group_start_y = origin[1] + counter[1];
            g.group_start_z = origin[2] + counter[2];
            g.group_number = next_id;
            next_id = next_id + 1;
            done = 1'b1;
            for (i = 0; i < dims_used; i++)
            begin
                c = counter[i] + stride[i];
                if (c < limit[i])
                begin
                    counter[i] = c;
                    done = 1'b0;
                    break;
                end
                counter[i] = '0;
            end
            g.last_group = done;
            if (done)
                range_active = 1'b0;
            issued++;
            return g;
        endfunction

        function void note_request(req_t r);
            rsp_t            res;
            int unsigned     cores;
            int unsigned     dnum;
            int unsigned     factor;
            int              ndims;
            int              d;
            logic [31:0]     gsz[3];
            logic [31:0]     lim[3];
            logic [31:0]     off[3];
            logic [10:0]     lsz[3];
            bit              work;
            longint unsigned prod;
            longint unsigned lprod;
            res = '0;
            if (r.cmd == CMD_NEXT)
            begin
                if (range_active)
                    res = issue_group();
                else
                    empties++;
                expected_groups.push_back(res);
                return;
            end

            // launch: drop any running range
            launches++;
            range_active = 1'b0;
            cores = core_count_reg;
            if (cores == 0)
                cores = 1;
            if (cores > MAX_CORES)
                cores = MAX_CORES;
            dnum = core_index_reg;
            ndims = r.num_dims;
            if (ndims == 0)
                ndims = 1;
            if (ndims > NUM_DIMS)
                ndims = NUM_DIMS;
            gsz = '{r.global_size_x, r.global_size_y, r.global_size_z};
            lsz = '{r.local_size_x, r.local_size_y, r.local_size_z};
            off = '{r.offset_x, r.offset_y, r.offset_z};
            foreach (lsz[i])
            begin
                if (lsz[i] == 0)
                    lsz[i] = 11'd1;
                lim[i] = gsz[i];
            end

            // split search, highest used dimension first
            if (r.debug_mode)
                work = (dnum == 0) || (cores == 1);
            else if (cores == 1)
                work = 1'b1;
            else
            begin
                work = (dnum == 0);
                for (d = ndims - 1; d >= 0; d--)
                begin
                    if (gsz[d] % cores == 0 && (gsz[d] / cores) % lsz[d] == 0)
                    begin
                        lim[d] = gsz[d] / cores;
                        off[d] = off[d] + dnum * lim[d];
                        work = 1'b1;
                        splits++;
                        break;
                    end
                end
            end
            if (!work)
            begin
                empties++;
                expected_groups.push_back(res);
                return;
            end

            // first linear id of this core's chunk, products mod 2^32
            factor = (cores > 1) ? dnum : 0;
            prod = factor * lim[0];
            prod = (prod & 64'hFFFF_FFFF) * lim[1];
            prod = (prod & 64'hFFFF_FFFF) * lim[2];
            prod = prod & 64'hFFFF_FFFF;
            lprod = ((lsz[0] * lsz[1]) & 64'hFFFF_FFFF) * lsz[2];
            lprod = lprod & 64'hFFFF_FFFF;
            if (lprod == 0)
                lprod = 1;
            foreach (counter[i])
            begin
                counter[i] = '0;
                limit[i] = lim[i];
                origin[i] = off[i];
                stride[i] = lsz[i];
            end
            dims_used = ndims;
            next_id = prod / lprod;
            range_active = 1'b1;
            res = issue_group();
            expected_groups.push_back(res);
        endfunction

        function void check_group(rsp_t got);
            rsp_t exp;
            bit   bad;
            if (expected_groups.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: unexpected result beat %h", $realtime, got);
                return;
            end
            exp = expected_groups.pop_front();
            checked++;
            bad = (got.valid_res !== exp.valid_res)
                || (got.group_start_x !== exp.group_start_x)
                || (got.group_start_y !== exp.group_start_y)
                || (got.group_start_z !== exp.group_start_z)
                || (got.group_number !== exp.group_number)
                || (got.last_group !== exp.last_group);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                begin
                    $display("%0t: result %0d mismatch", $realtime, checked);
                    $display("  exp: v=%b start=%h/%h/%h id=%h last=%b",
                        exp.valid_res, exp.group_start_x, exp.group_start_y,
                        exp.group_start_z, exp.group_number, exp.last_group);
                    $display("  got: v=%b start=%h/%h/%h id=%h last=%b",
                        got.valid_res, got.group_start_x, got.group_start_y,
                        got.group_start_z, got.group_number, got.last_group);
                end
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    ndwd_stream_if #(.T(req_t)) req_if ();
    ndwd_stream_if #(.T(rsp_t)) rsp_if ();

    dispatch_tracker tracker;
    int unsigned     idle_pct;
    int unsigned     stall_pct;
    int unsigned     sent_items;
    int unsigned     share_cores;
    int unsigned     settings_used;
    logic            hold_pending;
    int              hold_left = 0;

    // core settings per phase; covers zero, saturation and index bit 3
    int unsigned count_tbl[NUM_PHASES] = '{1, 8, 4, 2, 0, 15, 8, 3, 5, 8, 7, 1};
    int unsigned index_tbl[NUM_PHASES] = '{0, 7, 1, 0, 3, 9, 0, 5, 4, 15, 6, 4};

    ndrange_workgroup_dispatch u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side: check each beat taken, then pick ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            tracker.check_group(rsp_if.data);
        if (hold_pending)
        begin
            hold_left = HOLD_CYCLES;
            hold_pending <= 1'b0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            rsp_if.ready <= 1'b0;
        end
        else
            rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic req_t random_beat();
        req_t r;
        r.cmd = $urandom_range(1);
        r.num_dims = $urandom_range(3);
        r.global_size_x = $urandom;
        r.global_size_y = $urandom;
        r.global_size_z = $urandom;
        r.local_size_x = $urandom_range(2047);
        r.local_size_y = $urandom_range(2047);
        r.local_size_z = $urandom_range(2047);
        r.offset_x = $urandom;
        r.offset_y = $urandom;
        r.offset_z = $urandom;
        r.debug_mode = $urandom_range(1);
        return r;
    endfunction

    function automatic req_t next_beat();
        req_t r;
        r = random_beat();
        r.cmd = CMD_NEXT;
        return r;
    endfunction

    // Well-formed launch with a handful of groups; one dim may be built to split
    function automatic req_t build_range(int unsigned cores);
        req_t        r;
        int unsigned ndims;
        int unsigned sdim;
        int unsigned i;
        logic [10:0] l[3];
        logic [31:0] g[3];
        r = random_beat();
        r.cmd = CMD_LAUNCH;
        ndims = $urandom_range(1, 3);
        sdim = $urandom_range(0, ndims);
        for (i = 0; i < 3; i++)
        begin
            l[i] = ($urandom_range(9) == 0) ? $urandom_range(1, 1024) : $urandom_range(1, 6);
            if (i >= ndims)
                g[i] = ($urandom_range(3) == 0) ? $urandom_range(1, 64) : 1;
            else if (i == sdim)
                g[i] = l[i] * $urandom_range(1, 3) * cores;
            else
                g[i] = l[i] * $urandom_range(1, 3) - $urandom_range(0, l[i] - 1);
        end
        r.num_dims = ndims;
        r.global_size_x = g[0];
        r.global_size_y = g[1];
        r.global_size_z = g[2];
        r.local_size_x = l[0];
        r.local_size_y = l[1];
        r.local_size_z = l[2];
        r.debug_mode = ($urandom_range(7) == 0);
        if ($urandom_range(15) == 0)
            r.global_size_x = '0;
        return r;
    endfunction

    // One beat on req; valid stays high when the next beat follows at once
    task automatic send_request(input req_t beat);
        int unsigned gap;
        gap = 0;
        while (gap < 16 && $urandom_range(99) < idle_pct)
            gap++;
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= beat;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        tracker.note_request(beat);
        sent_items++;
    endtask

    task automatic launch_range(input logic [1:0] nd, input word_t gx, input word_t gy,
                                input word_t gz, input lsz_t lx, input lsz_t ly,
                                input lsz_t lz, input word_t ox, input word_t oy,
                                input word_t oz, input logic dbg);
        req_t r;
        r = '{cmd: CMD_LAUNCH, num_dims: nd, global_size_x: gx, global_size_y: gy,
              global_size_z: gz, local_size_x: lx, local_size_y: ly, local_size_z: lz,
              offset_x: ox, offset_y: oy, offset_z: oz, debug_mode: dbg};
        send_request(r);
    endtask

    task automatic drain_range();
        while (tracker.range_active)
            send_request(next_beat());
    endtask

    // Stop offering and wait until every expected result is back
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic configure(input logic [3:0] count, input logic [3:0] index);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CORE_COUNT;
        cfg_wdata <= count;
        @(posedge clk);
        tracker.write_reg(REG_CORE_COUNT, count);
        cfg_index <= REG_CORE_INDEX;
        cfg_wdata <= index;
        @(posedge clk);
        tracker.write_reg(REG_CORE_INDEX, index);
        cfg_we <= 1'b0;
        @(posedge clk);
        share_cores = (count == 0) ? 1 : (count > MAX_CORES) ? MAX_CORES : count;
        settings_used++;
    endtask

    // Random part: mostly complete ranges, some cut short, some noise
    task automatic run_range();
        int unsigned n;
        if ($urandom_range(4) == 0)
        begin
            send_request(random_beat());
            repeat ($urandom_range(4)) send_request(random_beat());
        end
        else
        begin
            send_request(build_range(share_cores));
            n = 0;
            while (tracker.range_active && n < 40 && $urandom_range(19) != 0)
            begin
                send_request(next_beat());
                n++;
            end
            repeat ($urandom_range(2)) send_request(next_beat());
        end
    endtask

    initial
    begin
        #(5_000_000);
        $display("tb_ndrange_workgroup_dispatch: FAIL");
        $finish;
    end

    initial
    begin
        int          p;
        int unsigned phase_end;
        tracker = new();
        tracker.reset_state();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        hold_pending = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        sent_items = 0;
        share_cores = 1;
        settings_used = 1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset settings, single core
        send_request(next_beat());
        launch_range(2'd1, 32'd4, 32'd1, 32'd1, 11'd2, 11'd1, 11'd1, 32'd10, 32'd0, 32'd0, 1'b0);
        send_request(next_beat());
        send_request(next_beat());
        // zero dims, zero local and zero global sizes
        launch_range(2'd0, 32'd0, 32'd0, 32'd0, 11'd0, 11'd0, 11'd0, 32'd0, 32'd5, 32'd7, 1'b0);
        // all fields at their top, offsets wrap
        launch_range(2'd3, '1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b0);
        send_request(next_beat());
        // launch over a running range
        launch_range(2'd2, 32'd2, 32'd2, 32'd1, 11'd1, 11'd1, 11'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        send_request(next_beat());
        wait_idle();

        // four cores, core 2: split on z, then debug and unsplittable launches
        configure(4'd4, 4'd2);
        launch_range(2'd3, 32'd2, 32'd2, 32'd8, 11'd1, 11'd1, 11'd2, 32'd0, 32'd0, 32'd100, 1'b0);
        drain_range();
        launch_range(2'd3, 32'd2, 32'd2, 32'd8, 11'd1, 11'd1, 11'd2, 32'd0, 32'd0, 32'd100, 1'b1);
        launch_range(2'd2, 32'd3, 32'd3, 32'd3, 11'd1, 11'd1, 11'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        send_request(next_beat());
        wait_idle();

        // core count saturates, master runs unsplit
        configure(4'd15, 4'd0);
        launch_range(2'd1, 32'd3, 32'd1, 32'd1, 11'd2, 11'd1, 11'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        drain_range();
        wait_idle();

        // zero core count acts as one core
        configure(4'd0, 4'd13);
        launch_range(2'd1, 32'd2, 32'd1, 32'd1, 11'd1, 11'd1, 11'd1, 32'd3, 32'd0, 32'd0, 1'b0);
        drain_range();
        wait_idle();

        // core index beyond core count
        configure(4'd2, 4'd5);
        launch_range(2'd2, 32'd1, 32'd2, 32'd1, 11'd1, 11'd1, 11'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        launch_range(2'd1, 32'd6, 32'd1, 32'd1, 11'd3, 11'd1, 11'd1, 32'd0, 32'd0, 32'd0, 1'b0);
        wait_idle();

        // Random phases over core settings and idle patterns
        for (p = 0; p < NUM_PHASES; p++)
        begin
            configure(count_tbl[p], index_tbl[p]);
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 51; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 51; end
                default: begin idle_pct = 38; stall_pct = 38; end
            endcase
            // long receiver hold-off while requests keep coming
            if (p == 4)
                hold_pending <= 1'b1;
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end)
                run_range();
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Run covered %0d beats, %0d launches (%0d split), %0d groups, %0d empty.",
            sent_items, tracker.launches, tracker.splits, tracker.issued, tracker.empties);
        $display("%0d core settings, %0d results checked, %0d mismatches.",
            settings_used, tracker.checked, tracker.errors);
        if (tracker.errors == 0 && tracker.outstanding() == 0)
            $display("tb_ndrange_workgroup_dispatch: PASS");
        else
            $display("tb_ndrange_workgroup_dispatch: FAIL");
        $finish;
    end

endmodule
